@@ sv/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(label, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ sv/rled_pkg.sv @@
// shared types and constants of the rle palette image decoder
package rled_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF  = 256;
  localparam int unsigned PIXEL_COUNT_BITS_DEF = 21;
  localparam int unsigned PIXEL_CFG_W          = 20;
  localparam int unsigned COLOR_W              = 24;
  localparam int unsigned BYTE_W               = 8;

  localparam logic [PIXEL_CFG_W-1:0] PIXEL_COUNT_RST = 20'd1;
  localparam logic [BYTE_W-1:0]      LITERAL_BIAS    = 8'd127;
  localparam logic [BYTE_W-1:0]      REPEAT_BIAS     = 8'd1;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_BYTE    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_CUT      = 2'd2
  } status_e;

  // per-result info travelling alongside the palette read
  typedef struct packed {
    logic [BYTE_W-1:0] run;
    logic              eoi;
    status_e           status;
    logic              zero_color;
  } meta_t;

endpackage

@@ sv/rled_if.sv @@
// request channel interfaces: compressed input, run output, configuration write
interface rled_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  byte_value;
  logic [7:0]  palette_index;
  logic [23:0] palette_color;
  logic        last_byte;

  modport source (output valid, cmd, byte_value, palette_index, palette_color, last_byte,
                  input ready);
  modport sink   (input valid, cmd, byte_value, palette_index, palette_color, last_byte,
                  output ready);
endinterface

interface rled_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] run_length;
  logic       end_of_image;
  logic [1:0] status;

  modport source (output valid, red, green, blue, run_length, end_of_image, status,
                  input ready);
  modport sink   (input valid, red, green, blue, run_length, end_of_image, status,
                  output ready);
endinterface

interface rled_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] pixel_count;

  modport source (output valid, pixel_count, input ready);
  modport sink   (input valid, pixel_count, output ready);
endinterface

@@ sv/rled_palette_mem.sv @@
// palette memory: one write port, one registered read port
module rled_palette_mem #(
  parameter int unsigned ENTRIES = rled_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        wr_en_i,
  input  logic [7:0]  wr_idx_i,
  input  logic [23:0] wr_color_i,
  input  logic        rd_en_i,
  input  logic [7:0]  rd_idx_i,
  output logic [23:0] rd_color_o
);
  import rled_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);

  logic [COLOR_W-1:0] mem_q [ENTRIES];
  logic [COLOR_W-1:0] rdata_q;
  logic               rd_oor_q;
  logic               wr_in_range;
  logic               rd_in_range;

  assign wr_in_range = {24'd0, wr_idx_i} < ENTRIES;
  assign rd_in_range = {24'd0, rd_idx_i} < ENTRIES;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_in_range) begin
      mem_q[wr_idx_i[AW-1:0]] <= wr_color_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_oor_q <= !rd_in_range;
      if (rd_in_range) begin
        rdata_q <= mem_q[rd_idx_i[AW-1:0]];
      end
    end
  end

  assign rd_color_o = rd_oor_q ? '0 : rdata_q;

endmodule

@@ sv/rled_ctrl.sv @@
// packet decoder: phase, run and literal counters, pixel count and end status
module rled_ctrl #(
  parameter int unsigned PIXEL_COUNT_BITS = rled_pkg::PIXEL_COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [19:0]         cfg_pixel_count_i,
  input  logic                step_i,
  input  logic [7:0]          byte_value_i,
  input  logic                last_byte_i,
  output logic                emit_o,
  output rled_pkg::meta_t     meta_o
);
  import rled_pkg::*;

  localparam int unsigned PCB   = PIXEL_COUNT_BITS;
  localparam int unsigned CMP_W = (PCB > PIXEL_CFG_W) ? PCB : PIXEL_CFG_W;

  phase_e                 phase_q, phase_d;
  logic [BYTE_W-1:0]      lit_q, lit_d;
  logic [BYTE_W-1:0]      rep_q, rep_d;
  logic [PCB-1:0]         seen_q, seen_d;
  logic [PIXEL_CFG_W-1:0] pixel_count_q;

  phase_e            phase_n;
  logic [BYTE_W-1:0] lit_n, rep_n, run;
  logic              hdr;
  logic [PCB:0]      sum;
  logic [PCB-1:0]    seen_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= PIXEL_COUNT_RST;
    end else if (cfg_we_i) begin
      pixel_count_q <= cfg_pixel_count_i;
    end
  end

  always_comb begin
    phase_n = PH_HEADER;
    lit_n   = lit_q;
    rep_n   = rep_q;
    run     = '0;
    hdr     = 1'b0;
    case (phase_q)
      PH_REPEAT: begin
        run   = rep_q;
        rep_n = '0;
      end
      PH_LITERAL: begin
        run   = 8'd1;
        lit_n = (lit_q != '0) ? lit_q - 8'd1 : '0;
        if (lit_n != '0) begin
          phase_n = PH_LITERAL;
        end
      end
      default: begin
        hdr = 1'b1;
        if (!byte_value_i[7]) begin
          rep_n   = byte_value_i + REPEAT_BIAS;
          phase_n = PH_REPEAT;
        end else begin
          lit_n   = byte_value_i - LITERAL_BIAS;
          phase_n = PH_LITERAL;
        end
      end
    endcase

    // saturating pixel count
    sum    = {1'b0, seen_q} + (PCB+1)'(run);
    seen_n = sum[PCB] ? '1 : sum[PCB-1:0];

    emit_o            = !hdr || last_byte_i;
    meta_o.run        = run;
    meta_o.eoi        = last_byte_i;
    meta_o.zero_color = hdr;
    if (!last_byte_i) begin
      meta_o.status = ST_OK;
    end else if (hdr || phase_n != PH_HEADER) begin
      meta_o.status = ST_CUT;
    end else if (CMP_W'(seen_n) != CMP_W'(pixel_count_q)) begin
      meta_o.status = ST_MISMATCH;
    end else begin
      meta_o.status = ST_OK;
    end

    phase_d = phase_q;
    lit_d   = lit_q;
    rep_d   = rep_q;
    seen_d  = seen_q;
    if (step_i) begin
      if (last_byte_i) begin
        phase_d = PH_HEADER;
        lit_d   = '0;
        rep_d   = '0;
        seen_d  = '0;
      end else begin
        phase_d = phase_n;
        lit_d   = lit_n;
        rep_d   = rep_n;
        seen_d  = seen_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      lit_q   <= '0;
      rep_q   <= '0;
      seen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      rep_q   <= rep_d;
      seen_q  <= seen_d;
    end
  end

endmodule

@@ sv/rle_palette_image_decoder_top.sv @@
// top level of the rle palette image decoder
//
// in_i carries palette writes (cmd 0) and compressed bytes (cmd 1); a request is
// taken when valid and ready are both high. out_o carries one run per result:
// colour, run_length (0 on a status-only item), end_of_image and status.
// cfg_i writes pixel_count, the expected pixel total; it is always ready. It is
// written only while the decoder is idle; the user is bound to this, the block itself does not enforce it.
// A byte that yields a result reaches out_o through the read stage, where the
// palette read is registered as the byte is taken, and then the output
// register, which loads from the read stage once it is free.
// One request per cycle is sustained while out_o does not stall, set by the single palette read port.
// Palette writes and header bytes that are not last give no result.
// When out_o stalls, one more result is held in the read stage; in_i drops
// ready only once both stages are full.
// Reset clears the decoder state and sets pixel_count to 1; the palette is not
// cleared and must be written before it is read. After a last byte the decoder
// returns to its reset state while palette and pixel_count are kept.
module rle_palette_image_decoder_top #(
  parameter int unsigned PALETTE_ENTRIES  = rled_pkg::PALETTE_ENTRIES_DEF,
  parameter int unsigned PIXEL_COUNT_BITS = rled_pkg::PIXEL_COUNT_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rled_in_if.sink  in_i,
  rled_cfg_if.sink cfg_i,
  rled_out_if.source out_o
);
  import rled_pkg::*;

`include "assert_macros.svh"

  logic               accept;
  logic               step;
  logic               emit;
  meta_t              meta;
  logic [COLOR_W-1:0] rd_color;

  logic               s1_valid_q, s1_valid_d;
  meta_t              s1_meta_q;
  logic               out_valid_q, out_valid_d;
  meta_t              out_meta_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_free;
  logic               s1_adv;

  assign cfg_i.ready = 1'b1;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign accept     = in_i.valid && in_i.ready;
  assign step       = accept && (in_i.cmd == CMD_BYTE);

  rled_ctrl #(
    .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_i.valid),
    .cfg_pixel_count_i(cfg_i.pixel_count),
    .step_i           (step),
    .byte_value_i     (in_i.byte_value),
    .last_byte_i      (in_i.last_byte),
    .emit_o           (emit),
    .meta_o           (meta)
  );

  rled_palette_mem #(
    .ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk_i     (clk_i),
    .wr_en_i   (accept && (in_i.cmd == CMD_PALETTE)),
    .wr_idx_i  (in_i.palette_index),
    .wr_color_i(in_i.palette_color),
    .rd_en_i   (step),
    .rd_idx_i  (in_i.byte_value),
    .rd_color_o(rd_color)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (step && emit) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      s1_meta_q <= meta;
    end
    if (s1_adv) begin
      out_meta_q  <= s1_meta_q;
      out_color_q <= s1_meta_q.zero_color ? '0 : rd_color;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.red          = out_color_q[23:16];
  assign out_o.green        = out_color_q[15:8];
  assign out_o.blue         = out_color_q[7:0];
  assign out_o.run_length   = out_meta_q.run;
  assign out_o.end_of_image = out_meta_q.eoi;
  assign out_o.status       = out_meta_q.status;

  `ASSERT_RST(a_status_only, clk_i, rst_ni, out_valid_q && (out_meta_q.run == '0) |-> out_meta_q.eoi && (out_meta_q.status == ST_CUT), "status-only item without cut status")
  `ASSERT_RST(a_mid_ok, clk_i, rst_ni, out_valid_q && !out_meta_q.eoi |-> out_meta_q.status == ST_OK, "status set on an item before end of image")
  `ASSERT_RST(a_run_max, clk_i, rst_ni, out_valid_q |-> out_meta_q.run <= 8'd128, "run length above 128")
  `ASSERT_RST(a_full_stall, clk_i, rst_ni, s1_valid_q && out_valid_q && !out_o.ready |=> s1_valid_q && out_valid_q, "result dropped while output stalled")

endmodule

@@ verif/rle_palette_image_decoder_top_tb.sv @@
// testbench for the rle palette image decoder: predicted runs checked against the output channel
module rle_palette_image_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rled_pkg::*;

  localparam logic [BYTE_W-1:0]      LITERAL_HDR_MIN = 8'd128;
  localparam logic [PIXEL_CFG_W-1:0] PIX_CFG_MAX     = 20'd1046529;
  localparam longint                 PIX_SEEN_MAX    = (longint'(1) << PIXEL_COUNT_BITS_DEF) - 1;
  localparam int                     MAX_RUN         = 128;
  localparam int                     SETTLE_CYCLES   = 4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] run_length;
    logic       eoi;
    status_e    status;
  } run_t;

  logic clk;
  logic rst_n;

  rled_in_if  in_bus ();
  rled_out_if out_bus ();
  rled_cfg_if cfg_bus ();

  rle_palette_image_decoder_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .cfg_i  (cfg_bus),
    .out_o  (out_bus)
  );

  // decoder state as predicted
  logic [COLOR_W-1:0]              pal_mem [PALETTE_ENTRIES_DEF];
  bit                              pal_seen [PALETTE_ENTRIES_DEF];
  int                              pal_list [$];
  phase_e                          dec_phase;
  logic [7:0]                      lit_left;
  logic [7:0]                      rep_len;
  logic [PIXEL_COUNT_BITS_DEF-1:0] pix_seen;
  logic [PIXEL_CFG_W-1:0]          pix_target;
  run_t                            expected_runs [$];

  int err_cnt;
  int items_sent;
  int hold_cycles_req;
  bit idle_en;
  bit noise_en;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("rle_palette_image_decoder_top_tb: FAIL");
    $finish;
  end

  task automatic report_error(input string what, input int unsigned got,
                              input int unsigned want);
    $display("ERROR %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  function automatic void clear_decoder();
    dec_phase = PH_HEADER;
    lit_left  = '0;
    rep_len   = '0;
    pix_seen  = '0;
  endfunction

  function automatic void add_pixels(input int unsigned n);
    if (longint'(pix_seen) + n > PIX_SEEN_MAX) begin
      pix_seen = PIX_SEEN_MAX[PIXEL_COUNT_BITS_DEF-1:0];
    end else begin
      pix_seen = PIXEL_COUNT_BITS_DEF'(longint'(pix_seen) + n);
    end
  endfunction

  function automatic void decode_step(input cmd_e c, input logic [7:0] b,
                                      input logic [7:0] pidx, input logic [23:0] col,
                                      input logic lst);
    run_t        r;
    logic [23:0] rgb;
    logic [7:0]  n;
    if (c == CMD_PALETTE) begin
      pal_mem[pidx] = col;
      if (!pal_seen[pidx]) begin
        pal_seen[pidx] = 1'b1;
        pal_list.insert(pal_list.size(), int'(pidx));
      end
      return;
    end
    if (dec_phase == PH_REPEAT || dec_phase == PH_LITERAL) begin
      rgb = pal_mem[b];
      if (dec_phase == PH_REPEAT) begin
        n = rep_len;
        add_pixels(n);
        dec_phase = PH_HEADER;
        rep_len = '0;
      end else begin
        n = 8'd1;
        add_pixels(1);
        if (lit_left > 0) lit_left--;
        if (lit_left == 0) dec_phase = PH_HEADER;
      end
      r.red        = rgb[23:16];
      r.green      = rgb[15:8];
      r.blue       = rgb[7:0];
      r.run_length = n;
      r.eoi        = lst;
      if (!lst) r.status = ST_OK;
      else if (dec_phase != PH_HEADER) r.status = ST_CUT;
      else if (pix_seen != pix_target) r.status = ST_MISMATCH;
      else r.status = ST_OK;
      expected_runs.insert(expected_runs.size(), r);
      if (lst) clear_decoder();
    end else begin
      if (b < LITERAL_HDR_MIN) begin
        rep_len = b + REPEAT_BIAS;
        dec_phase = PH_REPEAT;
      end else begin
        lit_left = b - LITERAL_BIAS;
        dec_phase = PH_LITERAL;
      end
      if (lst) begin
        r = '0;
        r.eoi = 1'b1;
        r.status = ST_CUT;
        expected_runs.insert(expected_runs.size(), r);
        clear_decoder();
      end
    end
  endfunction

  // one request on the input channel, predicted once taken
  task automatic send_req(input cmd_e c, input logic [7:0] b, input logic [7:0] pidx,
                          input logic [23:0] col, input logic lst);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.cmd           <= c;
    in_bus.byte_value    <= b;
    in_bus.palette_index <= pidx;
    in_bus.palette_color <= col;
    in_bus.last_byte     <= lst;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    items_sent++;
    decode_step(c, b, pidx, col, lst);
  endtask

  function automatic logic [7:0] pick_index();
    return 8'(pal_list[$urandom_range(0, pal_list.size() - 1)]);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (noise_en && $urandom_range(0, 11) == 0) begin
      send_req(CMD_PALETTE, 8'($urandom), 8'($urandom), 24'($urandom), 1'($urandom));
    end
    send_req(CMD_BYTE, b, 8'($urandom), 24'($urandom), lst);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pixel_count(input logic [PIXEL_CFG_W-1:0] v);
    wait_idle();
    cfg_bus.valid       <= 1'b1;
    cfg_bus.pixel_count <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    pix_target = v;
  endtask

  // packets covering the given pixels, the final byte optionally marked last
  task automatic send_packets(input int pixels, input bit end_last);
    int left;
    int n;
    left = pixels;
    while (left > 0) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_RUN) : $urandom_range(1, 8);
      if (n > left) n = left;
      left -= n;
      if ($urandom_range(0, 1) == 0) begin
        send_byte(8'(n) - REPEAT_BIAS, 1'b0);
        send_byte(pick_index(), end_last && left == 0);
      end else begin
        send_byte(8'(n) + LITERAL_BIAS, 1'b0);
        for (int k = 0; k < n; k++) send_byte(pick_index(), end_last && left == 0 && k == n - 1);
      end
    end
  endtask

  task automatic send_image(input int target, input int kind);
    int t2;
    int n;
    int cut_at;
    if (kind == 0 && target <= 300) begin
      send_packets(target, 1'b1);
    end else if (kind <= 1) begin
      t2 = $urandom_range(1, (target + 8 < 300) ? target + 8 : 300);
      if (t2 == target) t2++;
      send_packets(t2, 1'b1);
    end else begin
      t2 = $urandom_range(0, 40);
      if (t2 > 0) send_packets(t2, 1'b0);
      if ($urandom_range(0, 1) == 0) begin
        send_byte(8'($urandom), 1'b1);
      end else begin
        n = $urandom_range(2, MAX_RUN);
        cut_at = $urandom_range(1, n - 1);
        send_byte(8'(n) + LITERAL_BIAS, 1'b0);
        for (int k = 1; k <= cut_at; k++) send_byte(pick_index(), k == cut_at);
      end
    end
  endtask

  task automatic test_directed_cases();
    idle_en = 1'b0;
    noise_en = 1'b0;
    send_req(CMD_PALETTE, 8'h00, 8'h00, 24'h000000, 1'b0);
    send_req(CMD_PALETTE, 8'hFF, 8'hFF, 24'hFFFFFF, 1'b0);
    send_req(CMD_PALETTE, 8'h3C, 8'hA5, 24'h5AA55A, 1'b1);
    // single pixel run, matches the reset pixel count
    send_byte(8'd0, 1'b0);
    send_byte(8'hFF, 1'b1);
    // single literal
    send_byte(LITERAL_HDR_MIN, 1'b0);
    send_byte(8'h00, 1'b1);
    // longest run, then a literal packet cut short
    send_byte(8'd127, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'd129, 1'b0);
    send_byte(8'hFF, 1'b1);
    // header as the last byte
    send_byte(8'd5, 1'b1);
    // pixel count mismatch
    send_byte(8'd1, 1'b0);
    send_byte(8'h00, 1'b1);
    // entry written, then read after one header byte
    send_req(CMD_PALETTE, 8'h00, 8'h5A, 24'h123456, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'h5A, 1'b1);
    // longest literal packet cut off
    send_byte(8'd255, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    idle_en = 1'b0;
    noise_en = 1'b0;
    set_pixel_count(20'd64);
    hold_cycles_req = 300;
    for (int i = 0; i < 32; i++) begin
      send_byte(8'd1, 1'b0);
      send_byte(pick_index(), i == 31);
    end
    wait_idle();
  endtask

  task automatic test_random_streams();
    int start;
    int phase_start;
    int sel;
    int p;
    logic [PIXEL_CFG_W-1:0] cnt;
    idle_en = 1'b1;
    noise_en = 1'b1;
    start = items_sent;
    p = 0;
    repeat (16) send_req(CMD_PALETTE, 8'($urandom), 8'($urandom), 24'($urandom), 1'b0);
    while (items_sent - start < 850) begin
      if (items_sent - start >= 720) idle_en = 1'b0;
      sel = $urandom_range(0, 9);
      if (p == 0 || (p > 1 && sel == 0)) cnt = 20'd1;
      else if (p == 1 || sel == 1) cnt = PIX_CFG_MAX;
      else cnt = PIXEL_CFG_W'($urandom_range(2, 300));
      set_pixel_count(cnt);
      p++;
      phase_start = items_sent;
      repeat ($urandom_range(1, 4)) begin
        send_req(CMD_PALETTE, 8'($urandom), 8'($urandom), 24'($urandom), 1'($urandom));
      end
      while (items_sent - phase_start < 60) begin
        sel = $urandom_range(0, 9);
        send_image(int'(cnt), (sel < 6) ? 0 : (sel < 8) ? 1 : 2);
      end
    end
    idle_en = 1'b0;
    wait_idle();
  endtask

  initial begin : out_ready_drive
    int stall;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_cycles_req > 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold_cycles_req) @(posedge clk);
        hold_cycles_req = 0;
        out_bus.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 13);
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : run_check
    run_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_runs.size() == 0) begin
        report_error("run with none pending, run_length", out_bus.run_length, 0);
      end else begin
        want = expected_runs.pop_front();
        if (out_bus.red !== want.red) report_error("red", out_bus.red, want.red);
        if (out_bus.green !== want.green) report_error("green", out_bus.green, want.green);
        if (out_bus.blue !== want.blue) report_error("blue", out_bus.blue, want.blue);
        if (out_bus.run_length !== want.run_length) begin
          report_error("run_length", out_bus.run_length, want.run_length);
        end
        if (out_bus.end_of_image !== want.eoi) begin
          report_error("end_of_image", out_bus.end_of_image, want.eoi);
        end
        if (out_bus.status !== want.status) report_error("status", out_bus.status, want.status);
      end
    end
  end

  initial begin
    err_cnt = 0;
    items_sent = 0;
    hold_cycles_req = 0;
    idle_en = 1'b0;
    noise_en = 1'b0;
    foreach (pal_mem[i]) begin
      pal_mem[i] = '0;
      pal_seen[i] = 1'b0;
    end
    clear_decoder();
    pix_target = PIXEL_COUNT_RST;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.cmd = CMD_PALETTE;
    in_bus.byte_value = '0;
    in_bus.palette_index = '0;
    in_bus.palette_color = '0;
    in_bus.last_byte = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.pixel_count = PIXEL_COUNT_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_output_backpressure();
    test_random_streams();
    repeat (8) @(posedge clk);
    if (expected_runs.size() != 0) report_error("runs left over", expected_runs.size(), 0);
    if (err_cnt == 0) begin
      $display("rle_palette_image_decoder_top_tb: PASS");
    end else begin
      $display("rle_palette_image_decoder_top_tb: FAIL");
    end
    $finish;
  end

endmodule
